// ----- hdl/i2cm_pkg.sv -----
// Shared types, constants and a helper function of the I2C master bit engine.
package i2cm_pkg;

  localparam int unsigned PHASE_COUNT_BITS = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned PHASE_W = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [32:0] CNT_MASK = (33'd1 << PHASE_COUNT_BITS) - 33'd1;
  localparam logic [CFG_W-1:0] PHASE_TICKS_RESET = 16'd10;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NOP  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_CMD  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    cmd_e       cmd;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } pins_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_out_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
    logic       rejected;
  } res_t;

  // Phase length: zero acts as one, and the length saturates to the counter range.
  function automatic logic [PHASE_COUNT_BITS-1:0] phase_limit(logic [CFG_W-1:0] ticks);
    logic [32:0] t;
    t = {17'd0, ticks};
    if (t > CNT_MASK) begin
      t = CNT_MASK;
    end
    if (t == 33'd0) begin
      t = 33'd1;
    end
    return t[PHASE_COUNT_BITS-1:0];
  endfunction

endpackage

// ----- hdl/i2cm_if.sv -----
// Handshake channel interfaces of the I2C master bit engine.
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] data_byte;
  logic       send_ack;
  logic       sda_in;
  modport source (output valid, output action, output data_byte, output send_ack,
                  output sda_in, input ready);
  modport sink (input valid, input action, input data_byte, input send_ack,
                input sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_out_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_received;
  logic       rejected;
  modport source (output valid, output scl_level, output sda_level, output sda_out_enable,
                  output busy_res, output done_res, output read_byte,
                  output ack_received, output rejected, input ready);
  modport sink (input valid, input scl_level, input sda_level, input sda_out_enable,
                input busy_res, input done_res, input read_byte,
                input ack_received, input rejected, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/i2cm_front.sv -----
// Front end: accepts input beats and classifies each one into a queue entry.
module i2cm_front (
  i2cm_in_if.sink         in_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output i2cm_pkg::item_t q_item_o
);

  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i;

  always_comb begin
    q_item_o.cmd       = i2cm_pkg::cmd_e'(in_i.action);
    q_item_o.data_byte = in_i.data_byte;
    q_item_o.send_ack  = in_i.send_ack;
    q_item_o.sda_in    = in_i.sda_in;
    unique case (in_i.action) inside
      i2cm_pkg::CMD_NONE: begin
        q_item_o.kind = i2cm_pkg::KIND_TICK;
      end
      i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP,
      i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_READ: begin
        q_item_o.kind = i2cm_pkg::KIND_CMD;
      end
      default: begin
        q_item_o.kind = i2cm_pkg::KIND_NOP;
      end
    endcase
  end

endmodule

// ----- hdl/i2cm_queue.sv -----
// Two-entry queue between the front end and the bit engine.
module i2cm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2cm_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output i2cm_pkg::item_t pop_item_o
);

  i2cm_pkg::item_t mem_q [i2cm_pkg::QUEUE_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'(i2cm_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- hdl/i2cm_back.sv -----
// Bit engine: runs the bus phase sequencer on queued entries and registers each result.
module i2cm_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [i2cm_pkg::PHASE_COUNT_BITS-1:0]  limit_i,
  input  logic                                   q_valid_i,
  input  i2cm_pkg::item_t                        q_item_i,
  output logic                                   q_pop_o,
  i2cm_out_if.source                             out_o
);

  localparam logic [4:0] WrLastBitPhase = 5'd24;
  localparam logic [4:0] WrStopPhase    = 5'd25;
  localparam logic [4:0] WrAckPhase     = 5'd26;
  localparam logic [4:0] RdLastBitPhase = 5'd16;
  localparam logic [4:0] RdAckPhase     = 5'd17;
  localparam logic [4:0] RdClkPhase     = 5'd18;

  i2cm_pkg::pins_t                       pins_q, pins_d;
  i2cm_pkg::cmd_e                        cmd_q, cmd_d;
  logic [i2cm_pkg::PHASE_W-1:0]          phase_q, phase_d;
  logic [i2cm_pkg::PHASE_COUNT_BITS-1:0] tick_q, tick_d;
  logic [1:0]                            wsub_q, wsub_d;
  logic [2:0]                            wbit_q, wbit_d;
  logic [7:0]                            shift_q, shift_d;
  logic                                  ack_send_q, ack_send_d;
  logic                                  ack_seen_q, ack_seen_d;
  logic [7:0]                            read_hold_q, read_hold_d;
  logic                                  out_valid_q;
  i2cm_pkg::res_t                        out_q, res_d;

  logic [i2cm_pkg::PHASE_COUNT_BITS-1:0] tick_inc;
  logic [i2cm_pkg::PHASE_W-1:0]          phase_inc;
  logic [i2cm_pkg::PHASE_W-1:0]          phase_m1;
  logic                                  done;
  logic                                  rej;

  function automatic logic [4:0] phase_total(i2cm_pkg::cmd_e c);
    logic [4:0] n;
    unique case (c)
      i2cm_pkg::CMD_START: n = 5'd2;
      i2cm_pkg::CMD_STOP:  n = 5'd3;
      i2cm_pkg::CMD_WRITE: n = 5'd28;
      i2cm_pkg::CMD_READ:  n = 5'd20;
      default:             n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic i2cm_pkg::pins_t enter_phase(i2cm_pkg::cmd_e c, logic [4:0] idx,
                                                  logic [1:0] sub, logic [2:0] bsel,
                                                  logic [7:0] sh, logic ack,
                                                  i2cm_pkg::pins_t p);
    i2cm_pkg::pins_t r;
    r = p;
    unique case (c)
      i2cm_pkg::CMD_START: begin
        if (idx == 5'd0) begin
          r.scl = 1'b1;
        end else begin
          r.drv = 1'b1;
          r.sda = 1'b0;
        end
      end
      i2cm_pkg::CMD_STOP: begin
        if (idx == 5'd0) begin
          r.drv = 1'b1;
          r.sda = 1'b0;
        end else if (idx == 5'd1) begin
          r.scl = 1'b1;
        end else begin
          r.drv = 1'b1;
          r.sda = 1'b1;
        end
      end
      i2cm_pkg::CMD_WRITE: begin
        if (idx < WrLastBitPhase) begin
          if (sub == 2'd0) begin
            r.scl = 1'b0;
          end else if (sub == 2'd1) begin
            r.drv = 1'b1;
            r.sda = sh[3'd7 - bsel];
          end else begin
            r.scl = 1'b1;
          end
        end else if (idx == WrLastBitPhase) begin
          r.scl = 1'b0;
        end else if (idx == WrStopPhase) begin
          r.drv = 1'b1;
          r.sda = 1'b1;
        end else if (idx == WrAckPhase) begin
          r.drv = 1'b0;
          r.scl = 1'b1;
        end else begin
          r.drv = 1'b1;
          r.sda = 1'b1;
          r.scl = 1'b0;
        end
      end
      i2cm_pkg::CMD_READ: begin
        if (idx == 5'd0) begin
          r.drv = 1'b0;
        end else if (idx <= RdLastBitPhase) begin
          r.scl = idx[0];
        end else if (idx == RdAckPhase) begin
          r.drv = 1'b1;
          r.sda = !ack;
        end else if (idx == RdClkPhase) begin
          r.scl = 1'b1;
        end else begin
          r.scl = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  assign q_pop_o   = q_valid_i && (!out_valid_q || out_o.ready);
  assign tick_inc  = tick_q + 1'b1;
  assign phase_inc = phase_q + 1'b1;
  assign phase_m1  = phase_q - 1'b1;

  always_comb begin
    pins_d      = pins_q;
    cmd_d       = cmd_q;
    phase_d     = phase_q;
    tick_d      = tick_q;
    wsub_d      = wsub_q;
    wbit_d      = wbit_q;
    shift_d     = shift_q;
    ack_send_d  = ack_send_q;
    ack_seen_d  = ack_seen_q;
    read_hold_d = read_hold_q;
    done        = 1'b0;
    rej         = 1'b0;
    case (q_item_i.kind)
      i2cm_pkg::KIND_CMD: begin
        if (cmd_q != i2cm_pkg::CMD_NONE) begin
          rej = 1'b1;
        end else begin
          cmd_d   = q_item_i.cmd;
          phase_d = '0;
          tick_d  = '0;
          wsub_d  = 2'd0;
          wbit_d  = 3'd0;
          if (q_item_i.cmd == i2cm_pkg::CMD_WRITE) begin
            shift_d = q_item_i.data_byte;
          end
          if (q_item_i.cmd == i2cm_pkg::CMD_READ) begin
            shift_d    = 8'd0;
            ack_send_d = q_item_i.send_ack;
          end
          pins_d = enter_phase(q_item_i.cmd, 5'd0, 2'd0, 3'd0, shift_d, ack_send_d, pins_q);
        end
      end
      i2cm_pkg::KIND_TICK: begin
        if (cmd_q != i2cm_pkg::CMD_NONE) begin
          tick_d = tick_inc;
          if (tick_inc >= limit_i) begin
            if (cmd_q == i2cm_pkg::CMD_WRITE && phase_q == WrAckPhase) begin
              ack_seen_d = !q_item_i.sda_in;
            end
            if (cmd_q == i2cm_pkg::CMD_READ && phase_q >= 5'd1 &&
                phase_q <= RdLastBitPhase && phase_q[0] && q_item_i.sda_in) begin
              shift_d[3'd7 - phase_m1[3:1]] = 1'b1;
            end
            tick_d = '0;
            if (phase_inc >= phase_total(cmd_q)) begin
              if (cmd_q == i2cm_pkg::CMD_READ) begin
                pins_d.sda  = 1'b1;
                read_hold_d = shift_d;
              end
              cmd_d   = i2cm_pkg::CMD_NONE;
              phase_d = '0;
              done    = 1'b1;
            end else begin
              phase_d = phase_inc;
              if (wsub_q == 2'd2) begin
                wsub_d = 2'd0;
                wbit_d = wbit_q + 1'b1;
              end else begin
                wsub_d = wsub_q + 1'b1;
              end
              pins_d = enter_phase(cmd_q, phase_inc, wsub_d, wbit_d, shift_d, ack_send_q,
                                   pins_q);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_d.scl_level      = pins_d.scl;
    res_d.sda_level      = pins_d.sda;
    res_d.sda_out_enable = pins_d.drv;
    res_d.busy_res       = (cmd_d != i2cm_pkg::CMD_NONE);
    res_d.done_res       = done;
    res_d.read_byte      = read_hold_d;
    res_d.ack_received   = ack_seen_d;
    res_d.rejected       = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pins_q      <= '{scl: 1'b1, sda: 1'b0, drv: 1'b0};
      cmd_q       <= i2cm_pkg::CMD_NONE;
      phase_q     <= '0;
      tick_q      <= '0;
      wsub_q      <= 2'd0;
      wbit_q      <= 3'd0;
      shift_q     <= 8'd0;
      ack_send_q  <= 1'b0;
      ack_seen_q  <= 1'b0;
      read_hold_q <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        pins_q      <= pins_d;
        cmd_q       <= cmd_d;
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        wsub_q      <= wsub_d;
        wbit_q      <= wbit_d;
        shift_q     <= shift_d;
        ack_send_q  <= ack_send_d;
        ack_seen_q  <= ack_seen_d;
        read_hold_q <= read_hold_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.scl_level      = out_q.scl_level;
  assign out_o.sda_level      = out_q.sda_level;
  assign out_o.sda_out_enable = out_q.sda_out_enable;
  assign out_o.busy_res       = out_q.busy_res;
  assign out_o.done_res       = out_q.done_res;
  assign out_o.read_byte      = out_q.read_byte;
  assign out_o.ack_received   = out_q.ack_received;
  assign out_o.rejected       = out_q.rejected;

endmodule

// ----- hdl/i2c_master_bit_engine.sv -----
// Top level of the I2C master bit engine: configuration register, front end, queue, engine.
//
// Usage: each input beat on in_i carries one action: a tick that advances bus time, or a
// start, stop, write byte or read byte command. Every input beat yields exactly one result
// beat on out_o with the pin levels, busy, done, the last read byte, the last ACK seen and
// a rejected flag for a command that arrived while busy. Codes five to seven pass as idle.
// The cfg_i channel writes phase_ticks, the number of ticks each bus phase lasts (zero acts
// as one); it is always ready. The user must write it only while no beat is in flight, as
// the block does not enforce this. A result beat passes through the queue entry and then
// the output register of the phase sequencer before it is presented on out_o. Throughput:
// one beat per cycle while out_o does not stall.
// The two-entry queue and the output register let the front accept beats while a result
// waits; once a stalled result sits in the output register, the queue takes two more beats
// and then in_i.ready drops.
// Reset: SCL high, SDA released, engine idle, phase_ticks ten, queue and output empty.
module i2c_master_bit_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cm_in_if.sink    in_i,
  i2cm_cfg_if.sink   cfg_i,
  i2cm_out_if.source out_o
);

  logic [i2cm_pkg::PHASE_COUNT_BITS-1:0] limit_q;
  logic                                  q_full;
  logic                                  q_push;
  logic                                  q_pop;
  logic                                  q_valid;
  i2cm_pkg::item_t                       push_item;
  i2cm_pkg::item_t                       pop_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= i2cm_pkg::phase_limit(i2cm_pkg::PHASE_TICKS_RESET);
    end else if (cfg_i.valid) begin
      limit_q <= i2cm_pkg::phase_limit(cfg_i.data);
    end
  end

  i2cm_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (push_item)
  );

  i2cm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  i2cm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .limit_i   (limit_q),
    .q_valid_i (q_valid),
    .q_item_i  (pop_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

// ----- hdl/i2cm_checker.sv -----
// Port-level checker of the I2C master bit engine and its bind statement.
module i2cm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input logic busy_res,
  input logic done_res,
  input logic rejected
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_done_not_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(done_res && rejected))
    else $error("done and rejected in the same beat");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && done_res |-> !busy_res)
    else $error("busy after a finished command");

  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && rejected |-> busy_res)
    else $error("rejected while idle");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .busy_res  (out_o.busy_res),
  .done_res  (out_o.done_res),
  .rejected  (out_o.rejected)
);
